// File: design/assert_macros.svh
// Assertion shorthands used by the checker file, ilt_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ILT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ILT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ilt_pkg.sv
package ilt_pkg;

  typedef enum logic [3:0] {
    PH_START,
    PH_PREFIX,
    PH_AFTER_PREFIX,
    PH_CMD,
    PH_GAP,
    PH_MID,
    PH_TRAIL_NEW,
    PH_TRAIL,
    PH_DEAD
  } phase_e;

  typedef enum logic [2:0] {
    KIND_PREFIX     = 3'd0,
    KIND_CMD        = 3'd1,
    KIND_PARAM      = 3'd2,
    KIND_PREFIX_END = 3'd3,
    KIND_LINE_END   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_CMD = 2'd1,
    ST_LIMIT  = 2'd2
  } status_e;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Width of the byte fields below the line end fields in the result word.
  localparam int unsigned LINE_END_ZERO_W = 43;

  typedef struct packed {
    logic [6:0] pad;
    logic [1:0] status;
    logic [3:0] param_count;
    logic [8:0] prefix_length;
    logic       has_at;
    logic       has_bang;
    logic [8:0] at_position;
    logic [8:0] bang_position;
    logic       is_trailing;
    logic       first_of_token;
    logic [3:0] param_index;
    logic [7:0] byte_out;
  } res_data_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

// File: design/irc_line_tokenizer_top.sv
// IRC line tokenizer. Feed one line byte per transaction with s_axis_tuser low, then one
// transaction with s_axis_tuser high to close the line. One byte is accepted every cycle while
// s_axis_tready is high; each result appears on the master side in the cycle after the transaction
// that caused it, held in a single output register. s_axis_tready drops only while that register
// holds a result that the master side has not taken. Separators yield no result; the space that
// closes a prefix yields a prefix end result and every end marker yields a line end result.
module irc_line_tokenizer_top
  import ilt_pkg::*;
#(
  parameter int MAX_PREFIX = 512,
  parameter int MAX_PARAMS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data
  input  logic        s_axis_tuser,  // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] byte_out, [11:8] param_index, [12] first_of_token, [13] is_trailing,
  // [22:14] bang_position, [31:23] at_position, [32] has_bang, [33] has_at,
  // [42:34] prefix_length, [46:43] param_count, [48:47] status, [55:49] zero
  output logic [55:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser   // [2:0] kind
);

  localparam int PW = $clog2(MAX_PREFIX + 1);
  localparam int CW = $clog2(MAX_PARAMS + 1);
  localparam int PX = (PW > 9) ? PW : 9;
  localparam int CX = (CW > 4) ? CW : 4;

  function automatic logic [8:0] sat9(input logic [PW-1:0] v);
    logic [PX-1:0] ext;
    ext = PX'(v);
    return (ext > PX'(511)) ? 9'd511 : ext[8:0];
  endfunction

  phase_e        phase_q, phase_d;
  logic [PW-1:0] off_q, off_d;
  logic [PW-1:0] bang_q, bang_d;
  logic [PW-1:0] at_q, at_d;
  logic          bang_seen_q, bang_seen_d;
  logic          at_seen_q, at_seen_d;
  logic [CW-1:0] cnt_q, cnt_d;
  status_e       err_q, err_d;

  logic          out_valid_q;
  kind_e         out_kind_q;
  res_data_t     out_data_q;

  logic          fire;
  logic          emit;
  kind_e         res_kind;
  res_data_t     res_data;
  logic [7:0]    b;
  logic          cnt_full;
  logic          off_full;
  logic [CX-1:0] idx_ext;
  logic [CX-1:0] cnt_ext;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign cnt_full      = cnt_q >= CW'(MAX_PARAMS);
  assign off_full      = off_q >= PW'(MAX_PREFIX);

  always_comb begin
    phase_d     = phase_q;
    off_d       = off_q;
    bang_d      = bang_q;
    at_d        = at_q;
    bang_seen_d = bang_seen_q;
    at_seen_d   = at_seen_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    if (s_axis_tuser) begin
      phase_d     = PH_START;
      off_d       = '0;
      bang_d      = '0;
      at_d        = '0;
      bang_seen_d = 1'b0;
      at_seen_d   = 1'b0;
      cnt_d       = '0;
      err_d       = ST_OK;
    end else begin
      unique case (phase_q)
        PH_START: begin
          if (b == CH_COLON) begin
            phase_d = PH_PREFIX;
          end else if (b == CH_SPACE) begin
            if (err_q == ST_OK) err_d = ST_NO_CMD;
            phase_d = PH_DEAD;
          end else begin
            phase_d = PH_CMD;
          end
        end
        PH_PREFIX: begin
          if (b == CH_SPACE) begin
            phase_d = PH_AFTER_PREFIX;
          end else if (off_full) begin
            if (err_q == ST_OK) err_d = ST_LIMIT;
          end else begin
            if (b == CH_BANG && !bang_seen_q) begin
              bang_seen_d = 1'b1;
              bang_d      = off_q;
            end
            if (b == CH_AT && !at_seen_q) begin
              at_seen_d = 1'b1;
              at_d      = off_q;
            end
            off_d = off_q + PW'(1);
          end
        end
        PH_AFTER_PREFIX: begin
          if (is_ws(b)) begin
            phase_d = PH_AFTER_PREFIX;
          end else if (b == CH_COLON) begin
            if (err_q == ST_OK) err_d = ST_NO_CMD;
            phase_d = PH_DEAD;
          end else begin
            phase_d = PH_CMD;
          end
        end
        PH_CMD: begin
          if (b == CH_SPACE) begin
            phase_d = PH_GAP;
          end else if (b == CH_COLON) begin
            if (cnt_full) begin
              if (err_q == ST_OK) err_d = ST_LIMIT;
              phase_d = PH_DEAD;
            end else begin
              cnt_d   = cnt_q + CW'(1);
              phase_d = PH_TRAIL_NEW;
            end
          end
        end
        PH_GAP: begin
          if (is_ws(b)) begin
            phase_d = PH_GAP;
          end else if (cnt_full) begin
            if (err_q == ST_OK) err_d = ST_LIMIT;
            phase_d = PH_DEAD;
          end else begin
            cnt_d   = cnt_q + CW'(1);
            phase_d = (b == CH_COLON) ? PH_TRAIL_NEW : PH_MID;
          end
        end
        PH_MID: begin
          if (b == CH_SPACE) phase_d = PH_GAP;
        end
        PH_TRAIL_NEW: phase_d = PH_TRAIL;
        PH_TRAIL:     phase_d = PH_TRAIL;
        PH_DEAD:      phase_d = PH_DEAD;
        default:      phase_d = PH_DEAD;
      endcase
    end
  end

  assign idx_ext = CX'(cnt_d - CW'(1));
  assign cnt_ext = CX'(cnt_q);

  always_comb begin
    emit     = 1'b0;
    res_kind = KIND_PARAM;
    res_data = '0;
    if (s_axis_tuser) begin
      emit                 = 1'b1;
      res_kind             = KIND_LINE_END;
      res_data.param_count = (cnt_ext > CX'(15)) ? 4'd15 : cnt_ext[3:0];
      res_data.status      = ((err_q == ST_OK) &&
                              (phase_q == PH_PREFIX || phase_q == PH_AFTER_PREFIX)) ?
                             ST_NO_CMD : err_q;
    end else begin
      unique case (phase_q)
        PH_START, PH_AFTER_PREFIX: begin
          if (!(is_ws(b) && phase_q == PH_AFTER_PREFIX) && b != CH_COLON &&
              !(b == CH_SPACE)) begin
            emit                    = 1'b1;
            res_kind                = KIND_CMD;
            res_data.byte_out       = b;
            res_data.first_of_token = 1'b1;
          end
        end
        PH_PREFIX: begin
          if (b == CH_SPACE) begin
            emit                   = 1'b1;
            res_kind               = KIND_PREFIX_END;
            res_data.bang_position = bang_seen_q ? sat9(bang_q) : 9'd0;
            res_data.at_position   = at_seen_q ? sat9(at_q) : 9'd0;
            res_data.has_bang      = bang_seen_q;
            res_data.has_at        = at_seen_q;
            res_data.prefix_length = sat9(off_q);
          end else if (!off_full) begin
            emit                    = 1'b1;
            res_kind                = KIND_PREFIX;
            res_data.byte_out       = b;
            res_data.first_of_token = (off_q == '0);
          end
        end
        PH_CMD: begin
          if (b != CH_SPACE && b != CH_COLON) begin
            emit              = 1'b1;
            res_kind          = KIND_CMD;
            res_data.byte_out = b;
          end
        end
        PH_GAP: begin
          if (!is_ws(b) && !cnt_full && b != CH_COLON) begin
            emit                    = 1'b1;
            res_data.byte_out       = b;
            res_data.param_index    = idx_ext[3:0];
            res_data.first_of_token = 1'b1;
          end
        end
        PH_MID: begin
          if (b != CH_SPACE) begin
            emit                 = 1'b1;
            res_data.byte_out    = b;
            res_data.param_index = idx_ext[3:0];
          end
        end
        PH_TRAIL_NEW, PH_TRAIL: begin
          emit                    = 1'b1;
          res_data.byte_out       = b;
          res_data.param_index    = idx_ext[3:0];
          res_data.first_of_token = (phase_q == PH_TRAIL_NEW);
          res_data.is_trailing    = 1'b1;
        end
        PH_DEAD: emit = 1'b0;
        default: emit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      off_q       <= '0;
      bang_q      <= '0;
      at_q        <= '0;
      bang_seen_q <= 1'b0;
      at_seen_q   <= 1'b0;
      cnt_q       <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q     <= phase_d;
        off_q       <= off_d;
        bang_q      <= bang_d;
        at_q        <= at_d;
        bang_seen_q <= bang_seen_d;
        at_seen_q   <= at_seen_d;
        cnt_q       <= cnt_d;
        err_q       <= err_d;
      end
      if (s_axis_tready) out_valid_q <= fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_kind_q <= res_kind;
      out_data_q <= res_data;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: design/ilt_checker.sv
`include "assert_macros.svh"

module ilt_checker
  import ilt_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  logic line_end_out;
  logic end_in;

  assign line_end_out = m_axis_tvalid && (m_axis_tuser == KIND_LINE_END);
  assign end_in       = s_axis_tvalid && s_axis_tready && s_axis_tuser;

  `ILT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result dropped under stall")
  `ILT_ASSERT_SAME(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "input stalled while empty")
  `ILT_ASSERT_NEXT(a_end_gives_line_end, end_in, line_end_out, "end marker without line end")
  `ILT_ASSERT_SAME(a_line_end_clean, line_end_out,
    m_axis_tdata[LINE_END_ZERO_W-1:0] == '0, "line end carries byte fields")

endmodule

bind irc_line_tokenizer_top ilt_checker u_ilt_checker (.*);
